FILE: rtl/core/ps2ca_pkg.sv
// types and constants for the ps2 command engine with acknowledge and retry
// no dependencies; imported by ps2ca_step, ps2_command_ack_retry_top and the testbench
package ps2ca_pkg;

  // controller protocol bytes
  localparam logic [7:0] PREFIX_AUX  = 8'hD4;
  localparam logic [7:0] RESP_ACK    = 8'hFA;
  localparam logic [7:0] RESP_RESEND = 8'hFE;

  // register reset values
  localparam logic [16:0] TIMEOUT_RESET = 17'd100000;
  localparam logic [2:0]  ATTEMPT_RESET = 3'd3;
  localparam logic [2:0]  READ_RESET    = 3'd4;
  localparam logic [16:0] TICKS_MAX     = 17'h1FFFF;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_ATTEMPT = 2'd1,
    CFG_READ    = 2'd2,
    CFG_NONE    = 2'd3
  } cfg_idx_t;

  // request codes
  typedef enum logic [1:0] {
    CMD_START       = 2'd0,
    CMD_WRITE_READY = 2'd1,
    CMD_RX_BYTE     = 2'd2,
    CMD_TICK        = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PREFIX = 2'd1,
    PH_DATA   = 2'd2,
    PH_RESP   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       aux_port;
    logic [7:0] send_byte;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       write_valid;
    logic       write_to_cmd_port;
    logic [7:0] write_byte;
    logic       done_res;
    logic       success;
    logic       busy_res;
  } out_t;

  typedef struct packed {
    logic [16:0] timeout_limit;
    logic [2:0]  attempt_limit;
    logic [2:0]  read_limit;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  attempt_count;
    logic [2:0]  reads_this_attempt;
    logic [16:0] wait_ticks;
    logic        latched_aux;
    logic [7:0]  latched_byte;
  } eng_state_t;

endpackage

FILE: rtl/core/ps2_command_ack_retry_top.sv
// top level of the ps2 host command engine with acknowledge and retry
// depends on ps2ca_pkg and ps2ca_step
//
// Usage:
//   in_*  : one request per item: start (byte and port), controller write
//           ready, response byte received, or time tick.
//   out_* : exactly one result per request: an optional controller write
//           (prefix 0xD4 to the command port, or the byte to the data port),
//           done/success flags and the busy flag after the request.
//   cfg_* : register writes (0 timeout, 1 attempts, 2 reads per attempt);
//           always ready, write only while no request is outstanding.
// Result: registered, and presented in the cycle after its request is taken.
// Throughput: one request per cycle but for the stall below; the engine state
//   and result register update in the same cycle from a single decode stage.
// Stall: while a result waits unread, in_ready follows out_ready, so a new
//   request is taken in the same cycle the pending result leaves.
// Reset: engine idle, counters cleared, registers at 100000 / 3 / 4,
//   no result pending.
module ps2_command_ack_retry_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ps2ca_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ps2ca_pkg::out_t   out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [16:0]       cfg_data
);
  import ps2ca_pkg::*;

  cfg_t       cfg_r;
  eng_state_t st_r;
  eng_state_t st_nxt;
  out_t       res_nxt;
  out_t       out_r;
  logic       out_valid_r;
  logic       in_take;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_take   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_limit <= TIMEOUT_RESET;
      cfg_r.attempt_limit <= ATTEMPT_RESET;
      cfg_r.read_limit    <= READ_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TIMEOUT: cfg_r.timeout_limit <= cfg_data;
        CFG_ATTEMPT: cfg_r.attempt_limit <= cfg_data[2:0];
        CFG_READ:    cfg_r.read_limit    <= cfg_data[2:0];
        default:     cfg_r               <= cfg_r;
      endcase
    end
  end

  // request decode
  ps2ca_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .req    (in_data),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // engine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_IDLE, default: '0};
    end else if (in_take) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_r <= res_nxt;
    end
  end

endmodule

FILE: rtl/core/ps2ca_step.sv
// next-state and result logic for one request of the ps2 command engine
// depends on ps2ca_pkg
module ps2ca_step (
  input  ps2ca_pkg::eng_state_t st,
  input  ps2ca_pkg::cfg_t       cfg,
  input  ps2ca_pkg::in_t        req,
  output ps2ca_pkg::eng_state_t st_nxt,
  output ps2ca_pkg::out_t       res
);
  import ps2ca_pkg::*;

  logic [2:0]  att_inc;
  logic        att_fail;
  logic [2:0]  rd_inc;
  logic        rd_over;
  logic [16:0] tick_inc;
  logic        timed_out;
  eng_state_t  retry_st;

  // shared pieces: counter increments and the state of a new attempt
  always_comb begin
    att_inc   = st.attempt_count + 3'd1;
    att_fail  = (att_inc >= cfg.attempt_limit) || (att_inc == 3'd0);
    rd_inc    = st.reads_this_attempt + 3'd1;
    rd_over   = (rd_inc >= cfg.read_limit) || (rd_inc == 3'd0);
    tick_inc  = (st.wait_ticks != TICKS_MAX) ? st.wait_ticks + 17'd1 : st.wait_ticks;
    timed_out = tick_inc >= cfg.timeout_limit;

    retry_st                    = st;
    retry_st.attempt_count      = att_inc;
    retry_st.reads_this_attempt = 3'd0;
    retry_st.wait_ticks         = 17'd0;
    if (att_fail) begin
      retry_st.phase = PH_IDLE;
    end else begin
      retry_st.phase = st.latched_aux ? PH_PREFIX : PH_DATA;
    end
  end

  // request decode
  always_comb begin
    st_nxt = st;
    res    = '0;
    unique case (cmd_t'(req.cmd))
      CMD_START: begin
        if (st.phase == PH_IDLE) begin
          st_nxt.latched_aux        = req.aux_port;
          st_nxt.latched_byte       = req.send_byte;
          st_nxt.attempt_count      = 3'd0;
          st_nxt.reads_this_attempt = 3'd0;
          st_nxt.wait_ticks         = 17'd0;
          st_nxt.phase              = req.aux_port ? PH_PREFIX : PH_DATA;
        end
      end
      CMD_WRITE_READY: begin
        if (st.phase == PH_PREFIX) begin
          res.write_valid       = 1'b1;
          res.write_to_cmd_port = 1'b1;
          res.write_byte        = PREFIX_AUX;
          st_nxt.phase          = PH_DATA;
          st_nxt.wait_ticks     = 17'd0;
        end else if (st.phase == PH_DATA) begin
          res.write_valid           = 1'b1;
          res.write_byte            = st.latched_byte;
          st_nxt.phase              = PH_RESP;
          st_nxt.reads_this_attempt = 3'd0;
          st_nxt.wait_ticks         = 17'd0;
        end
      end
      CMD_RX_BYTE: begin
        if (st.phase == PH_RESP) begin
          st_nxt.wait_ticks = 17'd0;
          if (req.rx_byte == RESP_ACK) begin
            st_nxt.phase              = PH_IDLE;
            st_nxt.reads_this_attempt = 3'd0;
            res.done_res              = 1'b1;
            res.success               = 1'b1;
          end else if (req.rx_byte == RESP_RESEND) begin
            st_nxt       = retry_st;
            res.done_res = att_fail;
          end else if (rd_over) begin
            st_nxt       = retry_st;
            res.done_res = att_fail;
          end else begin
            st_nxt.reads_this_attempt = rd_inc;
          end
        end
      end
      CMD_TICK: begin
        if (st.phase != PH_IDLE) begin
          st_nxt.wait_ticks = tick_inc;
          if (timed_out) begin
            if (st.phase == PH_RESP) begin
              st_nxt       = retry_st;
              res.done_res = att_fail;
            end else begin
              // write wait expired: fail at once
              st_nxt.phase              = PH_IDLE;
              st_nxt.wait_ticks         = 17'd0;
              st_nxt.reads_this_attempt = 3'd0;
              res.done_res              = 1'b1;
            end
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
    res.busy_res = (st_nxt.phase != PH_IDLE);
  end

endmodule

FILE: verif/tb_ps2_command_ack_retry_top.sv
// testbench for ps2_command_ack_retry_top: drives start, write-ready, response and tick requests
// and checks every result against an in-bench model of the command engine
// depends on ps2ca_pkg and the rtl of ps2_command_ack_retry_top
`timescale 1ns / 100ps

module tb_ps2_command_ack_retry_top;
  import ps2ca_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP    = 50;

  // engine model plus the queue of results still owed by the dut
  class ack_retry_board;
    logic [16:0] tmo_lim;
    logic [2:0]  att_lim;
    logic [2:0]  rd_lim;
    phase_t      phase;
    logic [2:0]  attempts;
    logic [2:0]  reads;
    logic [16:0] ticks;
    logic        aux_q;
    logic [7:0]  byte_q;
    out_t        results_due[$];
    int          mismatches;

    function new();
      tmo_lim    = TIMEOUT_RESET;
      att_lim    = ATTEMPT_RESET;
      rd_lim     = READ_RESET;
      phase      = PH_IDLE;
      attempts   = '0;
      reads      = '0;
      ticks      = '0;
      aux_q      = 1'b0;
      byte_q     = '0;
      mismatches = 0;
    endfunction

    function void report_mismatch(string what);
      // keep the log short when everything goes wrong
      if (mismatches < PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, what);
      mismatches++;
    endfunction

    function void write_register(cfg_idx_t idx, logic [16:0] value);
      case (idx)
        CFG_TIMEOUT: tmo_lim = value;
        CFG_ATTEMPT: att_lim = value[2:0];
        CFG_READ:    rd_lim  = value[2:0];
        default:     ;
      endcase
    endfunction

    function void go_idle();
      phase = PH_IDLE;
      ticks = '0;
      reads = '0;
    endfunction

    function void open_attempt();
      phase = aux_q ? PH_PREFIX : PH_DATA;
      reads = '0;
      ticks = '0;
    endfunction

    // count one more attempt; 1 when the attempts are used up
    function bit retry_exhausted();
      attempts = attempts + 3'd1;
      if (attempts >= att_lim || attempts == 3'd0) begin
        go_idle();
        return 1'b1;
      end
      open_attempt();
      return 1'b0;
    endfunction

    // apply one accepted request; returns 1 when the engine acted on it
    function bit note_request(in_t req);
      out_t res;
      bit   took;
      res  = '0;
      took = 1'b0;
      case (cmd_t'(req.cmd))
        CMD_START: begin
          if (phase == PH_IDLE) begin
            aux_q    = req.aux_port;
            byte_q   = req.send_byte;
            attempts = '0;
            open_attempt();
            took = 1'b1;
          end
        end
        CMD_WRITE_READY: begin
          if (phase == PH_PREFIX) begin
            res.write_valid       = 1'b1;
            res.write_to_cmd_port = 1'b1;
            res.write_byte        = PREFIX_AUX;
            phase = PH_DATA;
            ticks = '0;
            took  = 1'b1;
          end else if (phase == PH_DATA) begin
            res.write_valid = 1'b1;
            res.write_byte  = byte_q;
            phase = PH_RESP;
            reads = '0;
            ticks = '0;
            took  = 1'b1;
          end
        end
        CMD_RX_BYTE: begin
          if (phase == PH_RESP) begin
            took  = 1'b1;
            ticks = '0;
            if (req.rx_byte == RESP_ACK) begin
              phase = PH_IDLE;
              reads = '0;
              res.done_res = 1'b1;
              res.success  = 1'b1;
            end else if (req.rx_byte == RESP_RESEND) begin
              res.done_res = retry_exhausted();
            end else begin
              reads = reads + 3'd1;
              if (reads >= rd_lim || reads == 3'd0) res.done_res = retry_exhausted();
            end
          end
        end
        default: begin
          // tick: only counts while a wait is running
          if (phase != PH_IDLE) begin
            took = 1'b1;
            if (ticks != TICKS_MAX) ticks = ticks + 17'd1;
            if (ticks >= tmo_lim) begin
              if (phase == PH_RESP) begin
                res.done_res = retry_exhausted();
              end else begin
                go_idle();
                res.done_res = 1'b1;
              end
            end
          end
        end
      endcase
      res.busy_res = (phase != PH_IDLE);
      results_due.push_back(res);
      return took;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result %h with no request outstanding", got));
        return;
      end
      want = results_due.pop_front();
      if (got.write_valid !== want.write_valid)
        report_mismatch($sformatf("write_valid %b, want %b", got.write_valid, want.write_valid));
      if (got.write_to_cmd_port !== want.write_to_cmd_port)
        report_mismatch($sformatf("write_to_cmd_port %b, want %b",
                                  got.write_to_cmd_port, want.write_to_cmd_port));
      if (got.write_byte !== want.write_byte)
        report_mismatch($sformatf("write_byte %h, want %h", got.write_byte, want.write_byte));
      if (got.done_res !== want.done_res)
        report_mismatch($sformatf("done_res %b, want %b", got.done_res, want.done_res));
      if (got.success !== want.success)
        report_mismatch($sformatf("success %b, want %b", got.success, want.success));
      if (got.busy_res !== want.busy_res)
        report_mismatch($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  ack_retry_board board;
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;

  ps2_command_ack_retry_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stalls
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  function automatic in_t req_of(cmd_t c, logic aux, logic [7:0] sb, logic [7:0] rx);
    in_t r;
    r.cmd       = c;
    r.aux_port  = aux;
    r.send_byte = sb;
    r.rx_byte   = rx;
    return r;
  endfunction

  // send one request, with random idle cycles ahead of it
  task automatic send_request(input in_t req, output bit took);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    took = board.note_request(req);
  endtask

  // mostly well-formed requests for the current phase, some noise
  function automatic in_t pick_request(phase_t ph);
    in_t req;
    int  roll;
    req  = in_t'($urandom);
    roll = $urandom_range(99);
    if (roll < 12) return req;
    roll = $urandom_range(99);
    case (ph)
      PH_IDLE: req.cmd = CMD_START;
      PH_PREFIX, PH_DATA: req.cmd = (roll < 70) ? CMD_WRITE_READY : CMD_TICK;
      default: begin
        if (roll < 25) begin
          req.cmd     = CMD_RX_BYTE;
          req.rx_byte = RESP_ACK;
        end else if (roll < 40) begin
          req.cmd     = CMD_RX_BYTE;
          req.rx_byte = RESP_RESEND;
        end else if (roll < 75) begin
          req.cmd     = CMD_RX_BYTE;
        end else begin
          req.cmd     = CMD_TICK;
        end
      end
    endcase
    return req;
  endfunction

  task automatic run_random(int count);
    int done_cnt;
    bit took;
    done_cnt = 0;
    while (done_cnt < count) begin
      send_request(pick_request(board.phase), took);
      if (took) done_cnt++;
    end
  endtask

  // drive the running command to an ack so the engine ends idle
  task automatic finish_command();
    in_t req;
    bit  took;
    while (board.phase != PH_IDLE) begin
      req = in_t'($urandom);
      if (board.phase == PH_RESP) begin
        req.cmd     = CMD_RX_BYTE;
        req.rx_byte = RESP_ACK;
      end else begin
        req.cmd = CMD_WRITE_READY;
      end
      send_request(req, took);
    end
  endtask

  // stop sending, wait for every owed result, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (board.results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all registers back to back, plus the unused index
  task automatic apply_settings(logic [16:0] tmo, logic [2:0] att, logic [2:0] rd);
    cfg_idx_t    idx [4];
    logic [16:0] vals [4];
    idx[0] = CFG_TIMEOUT; vals[0] = tmo;
    idx[1] = CFG_ATTEMPT; vals[1] = {14'($urandom), att};
    idx[2] = CFG_READ;    vals[2] = {14'($urandom), rd};
    idx[3] = CFG_NONE;    vals[3] = 17'($urandom);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      board.write_register(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // main sequence
  initial begin
    in_t         opening[$];
    logic [16:0] set_tmo [6];
    logic [2:0]  set_att [6];
    logic [2:0]  set_rd  [6];
    bit          took;

    board = new();
    cycle_count   = 0;
    send_idle_pct = 27;
    recv_idle_pct = 48;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_NONE;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored requests, plain keyboard send, aux send with resend,
    // too many other bytes and attempts used up, all at reset settings
    opening = '{
      req_of(CMD_TICK,        1'b1, 8'hFF, 8'hFF),
      req_of(CMD_WRITE_READY, 1'b0, 8'h00, 8'h00),
      req_of(CMD_RX_BYTE,     1'b1, 8'hA5, RESP_ACK),
      req_of(CMD_START,       1'b0, 8'h00, 8'h5A),
      req_of(CMD_START,       1'b1, 8'hFF, 8'h00),
      req_of(CMD_RX_BYTE,     1'b0, 8'h00, 8'h12),
      req_of(CMD_WRITE_READY, 1'b1, 8'h3C, 8'hC3),
      req_of(CMD_WRITE_READY, 1'b0, 8'h00, 8'h00),
      req_of(CMD_RX_BYTE,     1'b0, 8'h00, RESP_ACK),
      req_of(CMD_START,       1'b1, 8'hFF, 8'hFF),
      req_of(CMD_TICK,        1'b0, 8'h00, 8'h00),
      req_of(CMD_WRITE_READY, 1'b0, 8'h00, 8'h00),
      req_of(CMD_WRITE_READY, 1'b0, 8'h00, 8'h00),
      req_of(CMD_RX_BYTE,     1'b0, 8'h00, RESP_RESEND),
      req_of(CMD_WRITE_READY, 1'b0, 8'h00, 8'h00),
      req_of(CMD_WRITE_READY, 1'b0, 8'h00, 8'h00),
      req_of(CMD_RX_BYTE,     1'b0, 8'h00, 8'h00),
      req_of(CMD_RX_BYTE,     1'b0, 8'h00, 8'h55),
      req_of(CMD_RX_BYTE,     1'b0, 8'h00, 8'hFF),
      req_of(CMD_RX_BYTE,     1'b0, 8'h00, 8'hAA),
      req_of(CMD_WRITE_READY, 1'b0, 8'h00, 8'h00),
      req_of(CMD_WRITE_READY, 1'b0, 8'h00, 8'h00),
      req_of(CMD_RX_BYTE,     1'b0, 8'h00, RESP_RESEND),
      req_of(CMD_TICK,        1'b0, 8'h00, 8'h00)
    };
    foreach (opening[i]) send_request(opening[i], took);
    settle();

    // lowest, zero, highest, then a few in between
    set_tmo = '{17'd1, 17'd0, 17'h1FFFF, 17'd5, 17'd3, 17'd2};
    set_att = '{3'd1,  3'd0,  3'd7,      3'd3,  3'd5,  3'd2};
    set_rd  = '{3'd1,  3'd0,  3'd7,      3'd2,  3'd4,  3'd6};

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin send_idle_pct = 27; recv_idle_pct = 48; end
        1: begin send_idle_pct = 48; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int k = 0; k < 2; k++) begin
        apply_settings(set_tmo[mode*2+k], set_att[mode*2+k], set_rd[mode*2+k]);
        run_random(100);
        finish_command();
        settle();
      end
    end

    if (board.results_due.size() != 0)
      board.report_mismatch($sformatf("%0d results never arrived", board.results_due.size()));
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/ps2ca_pkg.sv
rtl/core/ps2ca_step.sv
rtl/core/ps2_command_ack_retry_top.sv
verif/tb_ps2_command_ack_retry_top.sv
